// ----- hw/rtl/sv39_page_table_mapper_core_macros.svh -----
// assertion macros for the sv39 page table mapper
// no dependencies; included by the top level only
`ifndef SV39_PAGE_TABLE_MAPPER_CORE_MACROS_SVH
`define SV39_PAGE_TABLE_MAPPER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SV39M_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("sv39m assertion failed");

// next-cycle implication
`define SV39M_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("sv39m assertion failed");

`else

`define SV39M_ASSERT_IMP(label, ck, rn, ante, cons)
`define SV39M_ASSERT_NXT(label, ck, rn, ante, cons)

`endif

`endif

// ----- hw/rtl/sv39m_pkg.sv -----
// shared types and constants for the sv39 page table mapper
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package sv39m_pkg;

    localparam int VA_W       = 39;
    localparam int PPN_W      = 44;
    localparam int CNT_W      = 16;
    localparam int PERM_W     = 8;
    localparam int STAT_W     = 3;
    localparam int PTE_W      = 54;
    localparam int FLAG_W     = 10;
    localparam int VPN_W      = 9;
    localparam int PAGE_SHIFT = 12;
    localparam int PTE_V_BIT  = 0;
    localparam int CFG_W      = 64;
    localparam int PADDR_W    = 4;
    localparam int CFG_IDX_LSB = 3;

    localparam logic CFG_IDX_BASE = 1'b0;

    localparam logic OP_MAP    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STAT_W-1:0] STAT_MISALIGNED = 3'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO_COUNT = 3'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE      = 3'd3;
    localparam logic [STAT_W-1:0] STAT_REMAP      = 3'd4;
    localparam logic [STAT_W-1:0] STAT_NO_PAGE    = 3'd5;

    localparam logic [1:0] LVL_0 = 2'd0;
    localparam logic [1:0] LVL_1 = 2'd1;
    localparam logic [1:0] LVL_2 = 2'd2;

    typedef struct packed {
        logic              operation;
        logic [VA_W-1:0]   virt_addr;
        logic [PPN_W-1:0]  phys_page;
        logic [CNT_W-1:0]  page_count;
        logic [PERM_W-1:0] permissions;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PTE_W-1:0]  leaf_entry;
    } res_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_PAGE,
        S_EV2,
        S_RD1,
        S_EV1,
        S_RD0,
        S_EV0,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              clear_step;
        logic              load;
        logic              rd_en;
        logic              rd_root;
        logic [1:0]        rd_level;
        logic              follow;
        logic              alloc;
        logic              write_leaf;
        logic              take_leaf;
        logic              next_page;
        logic              set_status;
        logic [STAT_W-1:0] status_code;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic lookup;
        logic misaligned;
        logic zero_count;
        logic out_of_range;
        logic entry_valid;
        logic child_ok;
        logic store_full;
        logic last_page;
    } dp_stat_t;

endpackage

// ----- hw/rtl/sv39_page_table_mapper_core.sv -----
// top level of the sv39 page table mapper: apb register, controller and datapath
// depends on sv39m_pkg, sv39m_ctrl, sv39m_datapath and the assertion macro header
`timescale 1ns / 1ps

`include "sv39_page_table_mapper_core_macros.svh"

// Sv39 page table mapper. After reset the block runs a clearing pass over the
// table store with busy high; table_base_page may be written over apb
// meanwhile. A request is taken when start is high and busy is low, and one
// result comes back per request on result, qualified by done for a single
// cycle; the receiver cannot stall it, so it must capture the result in that
// cycle. One request is worked at a time. A map of n pages walks them one
// after another and stops early on an error. Each of the three walk levels
// costs a read step and an evaluate step on the table store with its
// registered read data.
module sv39_page_table_mapper_core
    import sv39m_pkg::*;
#(
    parameter int TABLE_PAGES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  req_t               request,
    output logic               done,
    output res_t               result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]   pwdata,
    output logic [CFG_W-1:0]   prdata,
    output logic               pready
);

    logic [PPN_W-1:0] base_reg;
    logic             cfg_wr;
    dp_cmd_t          dp_cmd;
    dp_stat_t         dp_st;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_wr && paddr[CFG_IDX_LSB] == CFG_IDX_BASE)
        begin
            base_reg <= pwdata[PPN_W-1:0];
        end
    end

    assign prdata = (paddr[CFG_IDX_LSB] == CFG_IDX_BASE) ? CFG_W'(base_reg) : '0;

    sv39m_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .dp_st  (dp_st),
        .dp_cmd (dp_cmd),
        .busy   (busy),
        .done   (done)
    );

    sv39m_datapath #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .request    (request),
        .table_base (base_reg),
        .dp_st      (dp_st),
        .result     (result)
    );

    // result strobe only while a request is in flight, and for one cycle
    `SV39M_ASSERT_IMP(a_done_busy, clk, rst_n, done, busy)
    `SV39M_ASSERT_NXT(a_done_single, clk, rst_n, done, !done)
    `SV39M_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // failed results carry no leaf entry
    `SV39M_ASSERT_IMP(a_fail_no_leaf, clk, rst_n, done && result.status != STAT_OK, result.leaf_entry == '0)
    // the allocator never hands out a page beyond the store
    `SV39M_ASSERT_IMP(a_alloc_room, clk, rst_n, dp_cmd.alloc, !dp_st.store_full)

endmodule

// ----- hw/rtl/sv39m_store.sv -----
// table store: one write port, one read port with registered read data
// depends on sv39m_pkg
`timescale 1ns / 1ps

module sv39m_store
    import sv39m_pkg::*;
#(
    parameter int TABLE_PAGES = 64
)
(
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [$clog2(TABLE_PAGES)+VPN_W-1:0]        waddr,
    input  logic [PTE_W-1:0]                            wdata,
    input  logic                                        re,
    input  logic [$clog2(TABLE_PAGES)+VPN_W-1:0]        raddr,
    output logic [PTE_W-1:0]                            rdata
);

    localparam int DEPTH = TABLE_PAGES << VPN_W;

    logic [PTE_W-1:0] mem [DEPTH];
    logic [PTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/sv39m_ctrl.sv -----
// walk controller: clearing pass, input checks and the per-level walk sequence
// depends on sv39m_pkg; drives sv39m_datapath through dp_cmd_t
`timescale 1ns / 1ps

module sv39m_ctrl
    import sv39m_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t dp_st,
    output dp_cmd_t  dp_cmd,
    output logic     busy,
    output logic     done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                dp_cmd.clear_step = 1'b1;
                if (dp_st.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    dp_cmd.load = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!dp_st.lookup && dp_st.misaligned)
                begin
                    dp_cmd.set_status  = 1'b1;
                    dp_cmd.status_code = STAT_MISALIGNED;
                    state_next         = S_DONE;
                end
                else if (!dp_st.lookup && dp_st.zero_count)
                begin
                    dp_cmd.set_status  = 1'b1;
                    dp_cmd.status_code = STAT_ZERO_COUNT;
                    state_next         = S_DONE;
                end
                else
                begin
                    state_next = S_PAGE;
                end
            end
            S_PAGE:
            begin
                if (dp_st.out_of_range)
                begin
                    dp_cmd.set_status  = 1'b1;
                    dp_cmd.status_code = STAT_RANGE;
                    state_next         = S_DONE;
                end
                else
                begin
                    dp_cmd.rd_en    = 1'b1;
                    dp_cmd.rd_root  = 1'b1;
                    dp_cmd.rd_level = LVL_2;
                    state_next      = S_EV2;
                end
            end
            S_EV2, S_EV1:
            begin
                if (dp_st.entry_valid)
                begin
                    if (dp_st.child_ok)
                    begin
                        dp_cmd.follow = 1'b1;
                        state_next    = (state_reg == S_EV2) ? S_RD1 : S_RD0;
                    end
                    else
                    begin
                        dp_cmd.set_status  = 1'b1;
                        dp_cmd.status_code = STAT_NO_PAGE;
                        state_next         = S_DONE;
                    end
                end
                else if (dp_st.lookup || dp_st.store_full)
                begin
                    dp_cmd.set_status  = 1'b1;
                    dp_cmd.status_code = STAT_NO_PAGE;
                    state_next         = S_DONE;
                end
                else
                begin
                    dp_cmd.alloc = 1'b1;
                    state_next   = (state_reg == S_EV2) ? S_RD1 : S_RD0;
                end
            end
            S_RD1:
            begin
                dp_cmd.rd_en    = 1'b1;
                dp_cmd.rd_level = LVL_1;
                state_next      = S_EV1;
            end
            S_RD0:
            begin
                dp_cmd.rd_en    = 1'b1;
                dp_cmd.rd_level = LVL_0;
                state_next      = S_EV0;
            end
            S_EV0:
            begin
                if (dp_st.lookup)
                begin
                    if (dp_st.entry_valid)
                    begin
                        dp_cmd.take_leaf = 1'b1;
                    end
                    else
                    begin
                        dp_cmd.set_status  = 1'b1;
                        dp_cmd.status_code = STAT_NO_PAGE;
                    end
                    state_next = S_DONE;
                end
                else if (dp_st.entry_valid)
                begin
                    dp_cmd.set_status  = 1'b1;
                    dp_cmd.status_code = STAT_REMAP;
                    state_next         = S_DONE;
                end
                else
                begin
                    dp_cmd.write_leaf = 1'b1;
                    dp_cmd.next_page  = 1'b1;
                    state_next        = dp_st.last_page ? S_DONE : S_PAGE;
                end
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/sv39m_datapath.sv -----
// walk datapath: item registers, page allocator, entry decode and the table store
// depends on sv39m_pkg and sv39m_store; commanded by sv39m_ctrl
`timescale 1ns / 1ps

module sv39m_datapath
    import sv39m_pkg::*;
#(
    parameter int TABLE_PAGES = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          dp_cmd,
    input  req_t             request,
    input  logic [PPN_W-1:0] table_base,
    output dp_stat_t         dp_st,
    output res_t             result
);

    localparam int PAGE_W = $clog2(TABLE_PAGES);
    localparam int ADDR_W = PAGE_W + VPN_W;
    localparam int USED_W = $clog2(TABLE_PAGES + 1);

    logic              op_reg;
    logic [VA_W-1:0]   va_reg;
    logic [PPN_W-1:0]  pa_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PERM_W-1:0] perm_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [USED_W-1:0] used_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [STAT_W-1:0] status_reg;
    logic [PTE_W-1:0]  leaf_reg;

    logic [VPN_W-1:0]  vpn;
    logic [PAGE_W-1:0] rd_page;
    logic [ADDR_W-1:0] rd_addr;
    logic [PTE_W-1:0]  rdata;
    logic [PPN_W-1:0]  child;
    logic [PPN_W-1:0]  new_ppn;
    logic              st_we;
    logic [ADDR_W-1:0] st_waddr;
    logic [PTE_W-1:0]  st_wdata;

    always_comb
    begin
        case (dp_cmd.rd_level)
            LVL_2:   vpn = va_reg[PAGE_SHIFT + 2 * VPN_W +: VPN_W];
            LVL_1:   vpn = va_reg[PAGE_SHIFT + VPN_W +: VPN_W];
            default: vpn = va_reg[PAGE_SHIFT +: VPN_W];
        endcase
    end

    assign rd_page = dp_cmd.rd_root ? '0 : page_reg;
    assign rd_addr = {rd_page, vpn};

    // pointer page number relative to the store, modulo 2^44
    assign child   = rdata[PTE_W-1:FLAG_W] - table_base;
    assign new_ppn = table_base + PPN_W'(used_reg);

    always_comb
    begin
        st_we    = dp_cmd.clear_step | dp_cmd.alloc | dp_cmd.write_leaf;
        st_waddr = dp_cmd.clear_step ? clr_addr_reg : rd_addr_reg;
        if (dp_cmd.clear_step)
        begin
            st_wdata = '0;
        end
        else if (dp_cmd.alloc)
        begin
            st_wdata = {new_ppn, {(FLAG_W-1){1'b0}}, 1'b1};
        end
        else
        begin
            st_wdata = {pa_reg, {(FLAG_W-PERM_W){1'b0}}, perm_reg | PERM_W'(1)};
        end
    end

    sv39m_store #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (dp_cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= USED_W'(1);
            clr_addr_reg <= '0;
        end
        else
        begin
            if (dp_cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (dp_cmd.alloc)
            begin
                used_reg <= used_reg + USED_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            op_reg     <= request.operation;
            va_reg     <= request.virt_addr;
            pa_reg     <= request.phys_page;
            cnt_reg    <= request.page_count;
            perm_reg   <= request.permissions;
            status_reg <= STAT_OK;
            leaf_reg   <= '0;
        end
        if (dp_cmd.rd_en)
        begin
            rd_addr_reg <= rd_addr;
        end
        if (dp_cmd.follow)
        begin
            page_reg <= child[PAGE_W-1:0];
        end
        else if (dp_cmd.alloc)
        begin
            page_reg <= used_reg[PAGE_W-1:0];
        end
        if (dp_cmd.next_page)
        begin
            va_reg  <= va_reg + (VA_W'(1) << PAGE_SHIFT);
            pa_reg  <= pa_reg + PPN_W'(1);
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (dp_cmd.take_leaf)
        begin
            leaf_reg <= rdata;
        end
        if (dp_cmd.set_status)
        begin
            status_reg <= dp_cmd.status_code;
        end
    end

    always_comb
    begin
        dp_st.clear_last   = clr_addr_reg == ADDR_W'((TABLE_PAGES << VPN_W) - 1);
        dp_st.lookup       = op_reg == OP_LOOKUP;
        dp_st.misaligned   = va_reg[PAGE_SHIFT-1:0] != '0;
        dp_st.zero_count   = cnt_reg == '0;
        dp_st.out_of_range = va_reg[VA_W-1];
        dp_st.entry_valid  = rdata[PTE_V_BIT];
        dp_st.child_ok     = child < PPN_W'(used_reg);
        dp_st.store_full   = used_reg >= USED_W'(TABLE_PAGES);
        dp_st.last_page    = cnt_reg == CNT_W'(1);
    end

    assign result.status     = status_reg;
    assign result.leaf_entry = leaf_reg;

endmodule
